/* src/rbacp_pkg.sv */
`default_nettype none
package rbacp_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int LEN_WIDTH   = 32;
	localparam int NUM_WIDTH   = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [2:0] EV_FRAME = 3'd0;
	localparam logic [2:0] EV_BODY  = 3'd1;
	localparam logic [2:0] EV_TOKEN = 3'd2;
	localparam logic [2:0] EV_CMD   = 3'd3;
	localparam logic [2:0] EV_ERROR = 3'd4;

	typedef enum logic [9:0] {
		PH_STAR   = 10'b00_0000_0001,
		PH_CNUM   = 10'b00_0000_0010,
		PH_CLF    = 10'b00_0000_0100,
		PH_DOLLAR = 10'b00_0000_1000,
		PH_LNUM   = 10'b00_0001_0000,
		PH_LLF    = 10'b00_0010_0000,
		PH_BODY   = 10'b00_0100_0000,
		PH_BCR    = 10'b00_1000_0000,
		PH_BLF    = 10'b01_0000_0000,
		PH_ERR    = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
		logic       buffer_end;
	} rx_word_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  body_byte;
		logic [15:0] token_index;
		logic [31:0] token_length;
		logic [31:0] bytes_consumed;
		logic        need_more;
	} ev_word_t;

	typedef struct packed {
		logic                 ok;
		logic                 to_lf;
		logic                 neg;
		logic                 seen;
		logic [NUM_WIDTH-1:0] accum;
	} num_res_t;

endpackage
`default_nettype wire

/* src/rbacp_num_step.sv */
`default_nettype none
module rbacp_num_step
	import rbacp_pkg::*;
(
	input  wire logic [7:0]           data_byte,
	input  wire logic                 is_len,
	input  wire logic                 neg,
	input  wire logic                 seen,
	input  wire logic [NUM_WIDTH-1:0] accum,
	output num_res_t                  res
);

	logic [7:0]           diff;
	logic [NUM_WIDTH+3:0] prod;
	logic                 ovf;

	assign diff = data_byte - CH_ZERO;
	// accum*10 + digit, four guard bits catch any overflow
	assign prod = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {NUM_WIDTH'(0), diff[3:0]};
	assign ovf  = is_len ? (|prod[NUM_WIDTH+3:LEN_WIDTH]) : (|prod[NUM_WIDTH+3:COUNT_WIDTH]);

	always_comb begin
		res.ok    = 1'b0;
		res.to_lf = 1'b0;
		res.neg   = neg;
		res.seen  = seen;
		res.accum = accum;
		if (data_byte == CH_MINUS) begin
			res.ok  = !neg && !seen;
			res.neg = 1'b1;
		end else if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
			res.ok    = !ovf;
			res.accum = prod[NUM_WIDTH-1:0];
			res.seen  = 1'b1;
		end else if (data_byte == CH_CR) begin
			res.ok    = seen;
			res.to_lf = seen;
		end
	end

endmodule
`default_nettype wire

/* src/rbacp_parser.sv */
`default_nettype none
module rbacp_parser
	import rbacp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire rx_word_t word,
	output ev_word_t      res
);

	phase_t                 phase_q, ph, ph_n;
	logic                   neg_q, neg_e, neg_n;
	logic                   seen_q, seen_e, seen_n;
	logic [NUM_WIDTH-1:0]   acc_q, acc_e, acc_n;
	logic [COUNT_WIDTH-1:0] tl_q, tl_e, tl_n, tl_dec;
	logic [COUNT_WIDTH-1:0] tn_q, tn_e, tn_n;
	logic [LEN_WIDTH-1:0]   bl_q, bl_e, bl_n, bl_dec;
	logic [LEN_WIDTH-1:0]   blen_q, blen_e, blen_n;
	logic [31:0]            cons_q, cons_e, cons_n, used;
	logic [2:0]             ev;
	logic [7:0]             body;
	logic                   ok;
	logic                   num_neg_bad;
	logic [63:0]            tn_wide, blen_wide;
	num_res_t               num;
	wire logic [7:0]        b = word.data_byte;

	// restart wipes the state before this word is parsed
	always_comb begin
		if (word.restart) begin
			ph     = PH_STAR;
			neg_e  = 1'b0;
			seen_e = 1'b0;
			acc_e  = '0;
			tl_e   = '0;
			tn_e   = '0;
			bl_e   = '0;
			blen_e = '0;
			cons_e = '0;
		end else begin
			ph     = phase_q;
			neg_e  = neg_q;
			seen_e = seen_q;
			acc_e  = acc_q;
			tl_e   = tl_q;
			tn_e   = tn_q;
			bl_e   = bl_q;
			blen_e = blen_q;
			cons_e = cons_q;
		end
	end

	rbacp_num_step u_num (
		.data_byte (b),
		.is_len    (ph == PH_LNUM),
		.neg       (neg_e),
		.seen      (seen_e),
		.accum     (acc_e),
		.res       (num)
	);

	assign num_neg_bad = neg_e && (acc_e != '0);
	assign tl_dec      = tl_e - COUNT_WIDTH'(1);
	assign bl_dec      = bl_e - LEN_WIDTH'(1);

	always_comb begin
		ph_n   = ph;
		neg_n  = neg_e;
		seen_n = seen_e;
		acc_n  = acc_e;
		tl_n   = tl_e;
		tn_n   = tn_e;
		bl_n   = bl_e;
		blen_n = blen_e;
		cons_n = cons_e;
		ev     = EV_FRAME;
		body   = 8'h00;
		ok     = 1'b1;
		if (ph == PH_ERR) begin
			ev = EV_ERROR;
		end else begin
			if (cons_e != '1)
				cons_n = cons_e + 32'd1;
			case (ph)
				PH_STAR: begin
					if (b == CH_STAR) begin
						neg_n  = 1'b0;
						seen_n = 1'b0;
						acc_n  = '0;
						tl_n   = '0;
						tn_n   = '0;
						bl_n   = '0;
						blen_n = '0;
						ph_n   = PH_CNUM;
					end else begin
						ok = 1'b0;
					end
				end
				PH_CNUM, PH_LNUM: begin
					ok     = num.ok;
					neg_n  = num.neg;
					seen_n = num.seen;
					acc_n  = num.accum;
					if (num.to_lf)
						ph_n = (ph == PH_CNUM) ? PH_CLF : PH_LLF;
				end
				PH_CLF: begin
					if (b != CH_LF || num_neg_bad) begin
						ok = 1'b0;
					end else if (acc_e == '0) begin
						ev = EV_CMD;
					end else begin
						tl_n = acc_e[COUNT_WIDTH-1:0];
						ph_n = PH_DOLLAR;
					end
				end
				PH_DOLLAR: begin
					if (b == CH_DOLLAR) begin
						neg_n  = 1'b0;
						seen_n = 1'b0;
						acc_n  = '0;
						blen_n = '0;
						ph_n   = PH_LNUM;
					end else begin
						ok = 1'b0;
					end
				end
				PH_LLF: begin
					if (b != CH_LF || num_neg_bad) begin
						ok = 1'b0;
					end else begin
						blen_n = acc_e[LEN_WIDTH-1:0];
						bl_n   = acc_e[LEN_WIDTH-1:0];
						ph_n   = (acc_e == '0) ? PH_BCR : PH_BODY;
					end
				end
				PH_BODY: begin
					ev   = EV_BODY;
					body = b;
					bl_n = bl_dec;
					if (bl_dec == '0)
						ph_n = PH_BCR;
				end
				PH_BCR: begin
					if (b == CH_CR)
						ph_n = PH_BLF;
					else
						ok = 1'b0;
				end
				PH_BLF: begin
					if (b != CH_LF) begin
						ok = 1'b0;
					end else begin
						tl_n = tl_dec;
						if (tl_dec == '0) begin
							ev = EV_CMD;
						end else begin
							ev   = EV_TOKEN;
							tn_n = tn_e + COUNT_WIDTH'(1);
							ph_n = PH_DOLLAR;
						end
					end
				end
				default: ok = 1'b0;
			endcase
			if (!ok) begin
				ev   = EV_ERROR;
				ph_n = PH_ERR;
			end
		end
		used = cons_n;
		if (ev == EV_CMD) begin
			cons_n = '0;
			ph_n   = PH_STAR;
		end
	end

	assign tn_wide   = 64'(tn_e);
	assign blen_wide = 64'(blen_n);

	always_comb begin
		res.event_res      = ev;
		res.body_byte      = body;
		res.token_index    = tn_wide[15:0];
		res.token_length   = blen_wide[31:0];
		res.bytes_consumed = used;
		res.need_more      = word.buffer_end && (ev <= EV_TOKEN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STAR;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			acc_q   <= '0;
			tl_q    <= '0;
			tn_q    <= '0;
			bl_q    <= '0;
			blen_q  <= '0;
			cons_q  <= '0;
		end else if (step) begin
			phase_q <= ph_n;
			neg_q   <= neg_n;
			seen_q  <= seen_n;
			acc_q   <= acc_n;
			tl_q    <= tl_n;
			tn_q    <= tn_n;
			bl_q    <= bl_n;
			blen_q  <= blen_n;
			cons_q  <= cons_n;
		end
	end

	a_cmd_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.event_res == EV_CMD |=> phase_q == PH_STAR)
		else $error("command done did not rearm parser");

	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.event_res == EV_ERROR |=> phase_q == PH_ERR)
		else $error("error word did not enter error phase");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step && !word.restart && phase_q == PH_ERR |=> phase_q == PH_ERR && $stable(cons_q))
		else $error("error phase left without restart");

	a_cons_inc: assert property (@(posedge clk) disable iff (!arst_n)
		step && !word.restart && phase_q != PH_ERR && res.event_res != EV_CMD
			&& cons_q != '1 |=> cons_q == $past(cons_q) + 32'd1)
		else $error("byte count did not advance");

endmodule
`default_nettype wire

/* src/resp_bulk_array_command_parser.sv */
// Byte-stream parser for commands framed as an array of bulk strings:
// '*' count CRLF, then per token '$' length CRLF body CRLF.
//
// rx channel (rx_valid/rx_ready/rx_data): one stream byte per word, with
// restart (clear state and error, parse this byte fresh) and buffer_end.
// ev channel (ev_valid/ev_ready/ev_data): exactly one event word per rx
// word, in order: framing, body byte, token done, command done or error,
// plus token index, declared length, bytes consumed and need_more.
//
// Path: an accepted rx word goes into the input register, then its result
// into the result register, where ev_valid rises; a held result register
// stalls the move. Throughput: one byte per cycle while ev_ready is high;
// the whole phase update and the multiply-by-ten of the header number sit
// between the two registers. If ev_ready is low the result register holds,
// the input register still takes one more byte, and rx_ready then drops
// until the result is taken.
//
// Reset clears both valid flags and the parser state; the parser then
// expects '*'. An error is sticky until a word with restart set.
`default_nettype none
module resp_bulk_array_command_parser
	import rbacp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     rx_valid,
	output logic          rx_ready,
	input  wire rx_word_t rx_data,
	output logic          ev_valid,
	input  wire logic     ev_ready,
	output ev_word_t      ev_data
);

	logic     valid_s1;
	rx_word_t data_s1;
	logic     valid_s2;
	ev_word_t data_s2;
	logic     adv;
	ev_word_t res;

	assign adv      = valid_s1 && (!valid_s2 || ev_ready);
	assign rx_ready = !valid_s1 || adv;
	assign ev_valid = valid_s2;
	assign ev_data  = data_s2;

	rbacp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.word   (data_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rx_ready)
				valid_s1 <= rx_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (ev_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid)
			data_s1 <= rx_data;
		if (adv)
			data_s2 <= res;
	end

endmodule
`default_nettype wire

/* tb/resp_bulk_array_command_parser_tb.sv */
`timescale 1ns / 1ps
module resp_bulk_array_command_parser_tb
	import rbacp_pkg::*;
;

	class parse_tracker;
		localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
		localparam logic [63:0] LEN_MAX   = (64'd1 << LEN_WIDTH) - 64'd1;

		phase_t      phase;
		bit          neg;
		bit          seen;
		logic [63:0] accum;
		logic [15:0] left_tokens;
		logic [15:0] tok_num;
		logic [31:0] body_rem;
		logic [31:0] tok_len;
		logic [31:0] used_bytes;
		ev_word_t    want_q[$];
		int          errors;
		int          n_cmd;
		int          n_tok;
		int          n_body;
		int          n_err;
		int          n_restart;

		function new();
			clear_all();
		endfunction

		function void clear_number();
			neg = 1'b0;
			seen = 1'b0;
			accum = '0;
		endfunction

		function void clear_all();
			phase = PH_STAR;
			clear_number();
			left_tokens = '0;
			tok_num = '0;
			body_rem = '0;
			tok_len = '0;
			used_bytes = '0;
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		// one byte of a header number; 0 means a parse error
		function bit header_digit(logic [7:0] b, logic [63:0] lim, phase_t lf_phase);
			logic [63:0] d;
			d = 64'(b) - 64'(CH_ZERO);
			if (b == CH_MINUS) begin
				if (neg || seen)
					return 1'b0;
				neg = 1'b1;
				return 1'b1;
			end
			if (b >= CH_ZERO && b <= CH_NINE) begin
				if (accum > (lim - d) / 10)
					return 1'b0;
				accum = accum * 10 + d;
				seen = 1'b1;
				return 1'b1;
			end
			if (b == CH_CR && seen) begin
				phase = lf_phase;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void take_byte(rx_word_t w);
			ev_word_t    want;
			logic [2:0]  ev;
			logic [15:0] idx;
			bit          ok;
			ev = EV_FRAME;
			ok = 1'b1;
			want = '0;
			if (w.restart) begin
				clear_all();
				n_restart++;
			end
			idx = tok_num;
			if (phase == PH_ERR) begin
				ev = EV_ERROR;
			end else begin
				if (used_bytes != '1)
					used_bytes++;
				case (phase)
					PH_STAR: begin
						if (w.data_byte == CH_STAR) begin
							clear_number();
							left_tokens = '0;
							tok_num = '0;
							tok_len = '0;
							body_rem = '0;
							phase = PH_CNUM;
						end else begin
							ok = 1'b0;
						end
					end
					PH_CNUM: ok = header_digit(w.data_byte, COUNT_MAX, PH_CLF);
					PH_CLF: begin
						if (w.data_byte != CH_LF || (neg && accum != 0)) begin
							ok = 1'b0;
						end else if (accum == 0) begin
							ev = EV_CMD;
						end else begin
							left_tokens = accum[15:0];
							phase = PH_DOLLAR;
						end
					end
					PH_DOLLAR: begin
						if (w.data_byte == CH_DOLLAR) begin
							clear_number();
							tok_len = '0;
							phase = PH_LNUM;
						end else begin
							ok = 1'b0;
						end
					end
					PH_LNUM: ok = header_digit(w.data_byte, LEN_MAX, PH_LLF);
					PH_LLF: begin
						if (w.data_byte != CH_LF || (neg && accum != 0)) begin
							ok = 1'b0;
						end else begin
							tok_len = accum[31:0];
							body_rem = accum[31:0];
							phase = (body_rem == 0) ? PH_BCR : PH_BODY;
						end
					end
					PH_BODY: begin
						ev = EV_BODY;
						want.body_byte = w.data_byte;
						body_rem = body_rem - 1;
						if (body_rem == 0)
							phase = PH_BCR;
					end
					PH_BCR: begin
						if (w.data_byte == CH_CR)
							phase = PH_BLF;
						else
							ok = 1'b0;
					end
					PH_BLF: begin
						if (w.data_byte != CH_LF) begin
							ok = 1'b0;
						end else begin
							left_tokens = left_tokens - 1;
							if (left_tokens == 0) begin
								ev = EV_CMD;
							end else begin
								ev = EV_TOKEN;
								tok_num++;
								phase = PH_DOLLAR;
							end
						end
					end
					default: ok = 1'b0;
				endcase
				if (!ok) begin
					ev = EV_ERROR;
					phase = PH_ERR;
				end
			end
			want.event_res = ev;
			want.token_index = idx;
			want.token_length = tok_len;
			want.bytes_consumed = used_bytes;
			want.need_more = w.buffer_end && (ev <= EV_TOKEN);
			if (ev == EV_CMD) begin
				used_bytes = '0;
				phase = PH_STAR;
			end
			case (ev)
				EV_CMD:   n_cmd++;
				EV_TOKEN: n_tok++;
				EV_BODY:  n_body++;
				EV_ERROR: n_err++;
				default: ;
			endcase
			want_q.push_back(want);
		endfunction

		function void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
			if (got_v !== want_v) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, name, want_v, got_v);
				errors++;
			end
		endfunction

		function void match_event(ev_word_t got);
			ev_word_t want;
			if (want_q.size() == 0) begin
				$display("%0t: event word with nothing pending, expected none, actual 0x%0h",
					$time, got);
				errors++;
				return;
			end
			want = want_q.pop_front();
			check_field("event_res", 32'(want.event_res), 32'(got.event_res));
			check_field("body_byte", 32'(want.body_byte), 32'(got.body_byte));
			check_field("token_index", 32'(want.token_index), 32'(got.token_index));
			check_field("token_length", want.token_length, got.token_length);
			check_field("bytes_consumed", want.bytes_consumed, got.bytes_consumed);
			check_field("need_more", 32'(want.need_more), 32'(got.need_more));
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     rx_valid = 1'b0;
	logic     rx_ready;
	rx_word_t rx_data = '0;
	logic     ev_valid;
	logic     ev_ready = 1'b0;
	ev_word_t ev_data;

	parse_tracker tracker;
	rx_word_t     stim_q[$];
	int           ev_count = 0;

	resp_bulk_array_command_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_data  (rx_data),
		.ev_valid (ev_valid),
		.ev_ready (ev_ready),
		.ev_data  (ev_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void put_byte(logic [7:0] b, bit rst);
		rx_word_t w;
		w.data_byte = b;
		w.restart = rst;
		w.buffer_end = ($urandom_range(3) == 0);
		stim_q.push_back(w);
	endfunction

	function automatic void put_text(string s, bit rst);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i], rst && i == 0);
	endfunction

	// decimal header number followed by CRLF, sometimes with a leading zero
	function automatic void put_num(longint unsigned v, bit neg);
		string s;
		s = neg ? "-" : "";
		if ($urandom_range(9) == 0)
			s = {s, "0"};
		s = {s, $sformatf("%0d", v)};
		put_text(s, 1'b0);
		put_byte(CH_CR, 1'b0);
		put_byte(CH_LF, 1'b0);
	endfunction

	function automatic void put_command(bit rst);
		int unsigned n;
		int unsigned len;
		n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
		put_byte(CH_STAR, rst);
		put_num(n, n == 0 && $urandom_range(1) == 1);
		repeat (n) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
			put_byte(CH_DOLLAR, 1'b0);
			put_num(len, len == 0 && $urandom_range(3) == 0);
			repeat (len)
				put_byte(8'($urandom_range(255)), 1'b0);
			put_byte(CH_CR, 1'b0);
			put_byte(CH_LF, 1'b0);
		end
	endfunction

	function automatic void put_broken(bit rst);
		int    start;
		int    k;
		string bad_lines[6];
		bad_lines = '{"*\r\n", "*-\r\n", "*--1\r\n", "*1\r\n$\r\n", "*1\r\n$1\r\nab\r\n",
			"*1\r\n\r\n"};
		start = stim_q.size();
		case ($urandom_range(5))
			0: begin
				put_command(rst);
				k = $urandom_range(start, stim_q.size() - 1);
				stim_q[k].data_byte = 8'($urandom_range(255));
			end
			1: begin
				// cut short; the next command restarts
				put_command(rst);
				k = $urandom_range(start, stim_q.size() - 1);
				while (stim_q.size() > k)
					void'(stim_q.pop_back());
			end
			2: begin
				put_byte(CH_STAR, rst);
				if ($urandom_range(1)) begin
					put_num($urandom_range(1, 9), 1'b1);
				end else begin
					put_num(1, 1'b0);
					put_byte(CH_DOLLAR, 1'b0);
					put_num($urandom_range(1, 99), 1'b1);
				end
			end
			3: begin
				put_byte(CH_STAR, rst);
				if ($urandom_range(1)) begin
					put_num($urandom_range(65536, 999999), 1'b0);
				end else begin
					put_num(1, 1'b0);
					put_byte(CH_DOLLAR, 1'b0);
					put_num(64'd4294967296 + $urandom_range(0, 1 << 20), 1'b0);
				end
			end
			4: begin
				// largest legal count and length, then abandoned mid body
				put_byte(CH_STAR, rst);
				put_num(65535, 1'b0);
				put_byte(CH_DOLLAR, 1'b0);
				put_num(32'hFFFF_FFFF, 1'b0);
				repeat ($urandom_range(1, 4))
					put_byte(8'($urandom_range(255)), 1'b0);
			end
			default: put_text(bad_lines[$urandom_range(5)], rst);
		endcase
		repeat ($urandom_range(0, 2))
			put_byte(8'($urandom_range(255)), 1'b0);
	endfunction

	task automatic drive_words();
		for (int i = 0; i < stim_q.size(); i++) begin
			if (i == 700 || i == 900) begin
				while (tracker.pending() != 0) begin
					rx_valid = 1'b0;
					@(negedge clk);
				end
			end
			while (!(i >= 380 && i < 620) && $urandom_range(99) < 34) begin
				rx_valid = 1'b0;
				@(negedge clk);
			end
			rx_valid = 1'b1;
			rx_data = stim_q[i];
			@(posedge clk);
			while (!rx_ready)
				@(posedge clk);
			tracker.take_byte(stim_q[i]);
			@(negedge clk);
		end
		rx_valid = 1'b0;
	endtask

	// result side: random stalls, one long hold-off, one stretch always ready
	initial begin
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (ev_count == 150 && !held) begin
				held = 1'b1;
				ev_ready = 1'b0;
				repeat (300)
					@(negedge clk);
			end
			ev_ready = (ev_count >= 400 && ev_count < 620) || ($urandom_range(99) >= 34);
			@(posedge clk);
			if (ev_valid && ev_ready) begin
				tracker.match_event(ev_data);
				ev_count++;
			end
		end
	end

	initial begin
		#2000000;
		$display("Timeout: %0d event words still pending", tracker.pending());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		bit rst_next;
		bit broken;
		tracker = new();
		put_text("*-0\r\n", 1'b1);
		put_text("*1\r\n$0\r\n\r\n", 1'b0);
		put_text("*-1\r\n", 1'b0);
		put_text("*65536z", 1'b1);
		put_text("*\r", 1'b1);
		put_text("$", 1'b1);
		rst_next = 1'b1;
		while (stim_q.size() < 1030) begin
			broken = ($urandom_range(99) < 25);
			if (broken)
				put_broken(rst_next || $urandom_range(7) == 0);
			else
				put_command(rst_next || $urandom_range(7) == 0);
			rst_next = broken;
		end

		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		drive_words();
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		$display("Parsed %0d stream words with %0d restarts: %0d commands, %0d tokens closed,",
			stim_q.size(), tracker.n_restart, tracker.n_cmd, tracker.n_tok);
		$display("%0d body bytes and %0d error words, under random stalls on both sides",
			tracker.n_body, tracker.n_err);
		if (tracker.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* resp_bulk_array_command_parser.f */
src/rbacp_pkg.sv
src/rbacp_num_step.sv
src/rbacp_parser.sv
src/resp_bulk_array_command_parser.sv
tb/resp_bulk_array_command_parser_tb.sv
